FILE: rtl/pcpfl_pkg.sv
`timescale 1ns / 1ps

package pcpfl_pkg;

	localparam int ADDR_W = 40;

	// status codes
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_OOM = 2'd1;
	localparam logic [1:0] STAT_BAD = 2'd2;

	// request codes
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// register select, taken from paddr[3]
	localparam logic REG_START = 1'b0;
	localparam logic REG_STOP  = 1'b1;

	localparam logic [ADDR_W-1:0] START_RESET = 40'd0;
	localparam logic [ADDR_W-1:0] STOP_RESET  = 40'd134217728;

	typedef struct packed {
		logic [ADDR_W-1:0] region_start;
		logic [ADDR_W-1:0] region_stop;
		logic [ADDR_W:0]   base;          // region_start rounded up to a page
	} cfg_t;

endpackage

FILE: rtl/pcpfl_ram.sv
`timescale 1ns / 1ps

module pcpfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/pcpfl_cfg.sv
`timescale 1ns / 1ps

module pcpfl_cfg #(
	parameter int PAGE_SIZE = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	output pcpfl_pkg::cfg_t  cfg
);

	import pcpfl_pkg::*;

	localparam logic [ADDR_W:0] PG_MASK = (ADDR_W+1)'(PAGE_SIZE - 1);

	cfg_t cfg_q;
	logic wr;
	logic [ADDR_W:0] rnd;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign rnd    = ({1'b0, pwdata[ADDR_W-1:0]} + PG_MASK) & ~PG_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_start <= START_RESET;
			cfg_q.region_stop  <= STOP_RESET;
			cfg_q.base         <= {1'b0, START_RESET};
		end else if (wr) begin
			if (paddr[3] == REG_START) begin
				cfg_q.region_start <= pwdata[ADDR_W-1:0];
				cfg_q.base         <= rnd;
			end else begin
				cfg_q.region_stop <= pwdata[ADDR_W-1:0];
			end
		end
	end

	assign prdata = (paddr[3] == REG_STOP) ? 64'(cfg_q.region_stop) : 64'(cfg_q.region_start);
	assign cfg    = cfg_q;

endmodule

FILE: rtl/per_cpu_page_free_lists.sv
`timescale 1ns / 1ps

// channel  | handshake            | beat
// ---------+----------------------+------------------------------------
// in       | in_valid / in_ready  | req_type, cpu_id, page_addr
// out      | out_valid / out_ready| status, alloc_addr
// cfg      | psel/penable/pwrite  | paddr, pwdata (prdata on read)
//
// Each request passes through the EXEC state, which checks the address or
// picks a list and reads the link store, then the FIN state, which updates
// the list heads and registers the result. The synchronous link-store read
// of the head page makes the update wait for FIN. A new request is taken
// in FIN when the output register is free; a stalled output holds the block
// in FIN. Reset empties every list; the link store is not cleared.

module per_cpu_page_free_lists #(
	parameter int NUM_CPUS  = 8,
	parameter int PAGE_SIZE = 4096,
	parameter int MAX_PAGES = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [2:0]  cpu_id,
	input  logic [39:0] page_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [39:0] alloc_addr,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	import pcpfl_pkg::*;

	localparam int PW  = $clog2(MAX_PAGES);
	localparam int PSH = $clog2(PAGE_SIZE);
	localparam int IW  = ADDR_W + 1 - PSH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	cfg_t cfg;

	logic [1:0]  state_q;
	logic        accept;
	logic        out_free;
	logic        fin;

	logic        req_s1;
	logic [2:0]  cpu_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [PW-1:0]       head_q [NUM_CPUS];
	logic [NUM_CPUS-1:0] nonempty_q;

	logic [NUM_CPUS-1:0] own_vec;
	logic [NUM_CPUS-1:0] low_vec;
	logic [NUM_CPUS-1:0] sel_vec;
	logic [PW-1:0]       sel_page;
	logic                bad_chk;

	logic [NUM_CPUS-1:0] sel_vec_s2;
	logic [PW-1:0]       page_s2;
	logic                ne_s2;
	logic                bad_s2;
	logic [ADDR_W:0]     diff_s2;

	logic [IW-1:0] idx_full;
	logic [PW-1:0] idx;
	logic          free_bad;
	logic          push;
	logic          pop;
	logic [ADDR_W:0] page_byte;

	logic [PW:0] ram_rdata;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [ADDR_W-1:0] addr_q;

	pcpfl_cfg #(.PAGE_SIZE(PAGE_SIZE)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !out_valid_q || out_ready;
	assign fin      = (state_q == ST_FIN) && out_free;
	assign in_ready = (state_q == ST_IDLE) || fin;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) state_q <= in_valid ? ST_EXEC : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			cpu_s1  <= cpu_id;
			addr_s1 <= page_addr;
		end
	end

	// pick the list: own list for a free, own or first non-empty for an alloc
	always_comb begin
		low_vec = nonempty_q & (~nonempty_q + NUM_CPUS'(1));
		for (int i = 0; i < NUM_CPUS; i++) begin
			own_vec[i] = (32'(cpu_s1) == i);
		end
		if (req_s1 == REQ_FREE || (|(own_vec & nonempty_q))) begin
			sel_vec = own_vec;
		end else begin
			sel_vec = low_vec;
		end
		sel_page = '0;
		for (int i = 0; i < NUM_CPUS; i++) begin
			sel_page = sel_page | (head_q[i] & {PW{sel_vec[i]}});
		end
		bad_chk = (32'(cpu_s1) >= NUM_CPUS) || (|addr_s1[PSH-1:0])
			|| ({1'b0, addr_s1} < cfg.base) || (addr_s1 >= cfg.region_stop);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			sel_vec_s2 <= sel_vec;
			page_s2    <= sel_page;
			ne_s2      <= |(sel_vec & nonempty_q);
			bad_s2     <= bad_chk;
			diff_s2    <= {1'b0, addr_s1} - cfg.base;
		end
	end

	assign idx_full  = diff_s2[ADDR_W:PSH];
	assign idx       = idx_full[PW-1:0];
	assign free_bad  = bad_s2 || (idx_full >= IW'(MAX_PAGES));
	assign push      = fin && (req_s1 == REQ_FREE) && !free_bad;
	assign pop       = fin && (req_s1 == REQ_ALLOC) && ne_s2;
	assign page_byte = (ADDR_W+1)'(page_s2) << PSH;

	// link entry: {page below valid, page below}
	pcpfl_ram #(.WIDTH(PW + 1), .DEPTH(MAX_PAGES)) u_links (
		.clk   (clk),
		.we    (push),
		.waddr (idx),
		.wdata ({ne_s2, page_s2}),
		.re    (state_q == ST_EXEC),
		.raddr (sel_page),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				if (sel_vec_s2[i]) begin
					if (push) begin
						head_q[i]     <= idx;
						nonempty_q[i] <= 1'b1;
					end else if (pop) begin
						head_q[i]     <= ram_rdata[PW] ? ram_rdata[PW-1:0] : '0;
						nonempty_q[i] <= ram_rdata[PW];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			if (req_s1 == REQ_FREE) begin
				status_q <= free_bad ? STAT_BAD : STAT_OK;
				addr_q   <= '0;
			end else if (ne_s2) begin
				status_q <= STAT_OK;
				addr_q   <= ADDR_W'(cfg.base + page_byte);
			end else begin
				status_q <= STAT_OOM;
				addr_q   <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign alloc_addr = addr_q;

	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("request accepted but lookup not started");

	a_one_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> $onehot0(sel_vec_s2))
		else $error("more than one list selected");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (nonempty_q & $past(sel_vec_s2)) != '0)
		else $error("free did not mark list non-empty");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> addr_q[PSH-1:0] == '0)
		else $error("allocated address not page aligned");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != STAT_OK |-> addr_q == '0)
		else $error("failed request returned an address");

endmodule
